// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vertex normal estimator assertion failed");

// implication form built on the clocked macro
`define ASSERT_IMPLIES(label, clk, rst_n, cond, conseq) \
    `ASSERT_CLK(label, clk, rst_n, (cond) |-> (conseq))

`endif

// File: sv/vne_pkg.sv
// ---------------------------------------------------------------------------
// vne_pkg
// shared types and constants of the vertex normal estimator
// ---------------------------------------------------------------------------
package vne_pkg;

    // fixed field widths
    localparam int IDX_BITS  = 10;
    localparam int KIND_BITS = 2;
    localparam int CFG_BITS  = 11;
    localparam int NORM_BITS = 16;
    localparam int QUOT_BITS = 15;

    // item kinds
    localparam logic [KIND_BITS-1:0] KIND_WRITE    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ     = 2'd2;

    // result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // normalizer status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } norm_stat_t;

endpackage

// File: sv/vne_normalize.sv
// ---------------------------------------------------------------------------
// vne_normalize
// scales a 3-vector to a q1.14 unit vector: shift, square sum, bit-serial
// square root and restoring division, one step per cycle
// ---------------------------------------------------------------------------
module vne_normalize #(
    parameter int MAG_BITS = 43
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [MAG_BITS:0]              comp_x,
    input  logic signed [MAG_BITS:0]              comp_y,
    input  logic signed [MAG_BITS:0]              comp_z,
    output logic signed [vne_pkg::NORM_BITS-1:0]  norm_x,
    output logic signed [vne_pkg::NORM_BITS-1:0]  norm_y,
    output logic signed [vne_pkg::NORM_BITS-1:0]  norm_z,
    output vne_pkg::norm_stat_t                   stat
);
    import vne_pkg::*;

    localparam int MW = MAG_BITS + 1;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_SQRT,
        N_DLOAD,
        N_DSTEP
    } nstate_t;

    nstate_t                 state_reg;
    logic [MW-1:0]           mag_x_reg;
    logic [MW-1:0]           mag_y_reg;
    logic [MW-1:0]           mag_z_reg;
    logic [2:0]              neg_reg;
    logic [4:0]              cnt_reg;
    logic [1:0]              j_reg;
    logic [59:0]             prod_reg;
    logic [63:0]             s_reg;
    logic [63:0]             res_reg;
    logic [63:0]             bit_reg;
    logic [31:0]             rem_reg;
    logic [QUOT_BITS-1:0]    low_reg;
    logic [QUOT_BITS-1:0]    q_reg;
    logic                    done_reg;
    logic signed [NORM_BITS-1:0] nx_reg;
    logic signed [NORM_BITS-1:0] ny_reg;
    logic signed [NORM_BITS-1:0] nz_reg;

    logic [MW-1:0]           mx;
    logic [63:0]             mx64;
    logic [29:0]             sq_op;
    logic [29:0]             div_m;
    logic [30:0]             root;
    logic [44:0]             dividend;
    logic [63:0]             root_try;
    logic [32:0]             trial;
    logic                    qbit;
    logic [QUOT_BITS-1:0]    q_new;
    logic signed [NORM_BITS-1:0] q_signed;
    logic                    q_neg;

    // largest magnitude
    always_comb
    begin
        mx = mag_x_reg;
        if (mag_y_reg > mx)
        begin
            mx = mag_y_reg;
        end
        if (mag_z_reg > mx)
        begin
            mx = mag_z_reg;
        end
        mx64 = 64'(mx);
    end

    // operand selection for square and divide
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = mag_x_reg[29:0];
            2'd1:    sq_op = mag_y_reg[29:0];
            default: sq_op = mag_z_reg[29:0];
        endcase
        case (j_reg)
            2'd0:    div_m = mag_x_reg[29:0];
            2'd1:    div_m = mag_y_reg[29:0];
            default: div_m = mag_z_reg[29:0];
        endcase
        case (j_reg)
            2'd0:    q_neg = neg_reg[0];
            2'd1:    q_neg = neg_reg[1];
            default: q_neg = neg_reg[2];
        endcase
    end

    // square root and division step logic
    always_comb
    begin
        root     = res_reg[30:0];
        root_try = res_reg + bit_reg;
        dividend = {1'b0, div_m, 14'd0} + 45'(root[30:1]);
        trial    = {rem_reg, low_reg[QUOT_BITS-1]};
        qbit     = (trial >= 33'(root));
        q_new    = {q_reg[QUOT_BITS-2:0], qbit};
        q_signed = q_neg ? -NORM_BITS'(q_new) : NORM_BITS'(q_new);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            j_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        mag_x_reg <= comp_x[MAG_BITS] ? MW'(-comp_x) : MW'(comp_x);
                        mag_y_reg <= comp_y[MAG_BITS] ? MW'(-comp_y) : MW'(comp_y);
                        mag_z_reg <= comp_z[MAG_BITS] ? MW'(-comp_z) : MW'(comp_z);
                        neg_reg   <= {comp_z[MAG_BITS], comp_y[MAG_BITS], comp_x[MAG_BITS]};
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (mx == '0)
                    begin
                        nx_reg    <= '0;
                        ny_reg    <= '0;
                        nz_reg    <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else if ((mx64 >> 34) != 64'd0)
                    begin
                        mag_x_reg <= mag_x_reg >> 4;
                        mag_y_reg <= mag_y_reg >> 4;
                        mag_z_reg <= mag_z_reg >> 4;
                    end
                    else if ((mx64 >> 30) != 64'd0)
                    begin
                        mag_x_reg <= mag_x_reg >> 1;
                        mag_y_reg <= mag_y_reg >> 1;
                        mag_z_reg <= mag_z_reg >> 1;
                    end
                    else if ((mx64 >> 25) == 64'd0)
                    begin
                        mag_x_reg <= mag_x_reg << 4;
                        mag_y_reg <= mag_y_reg << 4;
                        mag_z_reg <= mag_z_reg << 4;
                    end
                    else if ((mx64 >> 29) == 64'd0)
                    begin
                        mag_x_reg <= mag_x_reg << 1;
                        mag_y_reg <= mag_y_reg << 1;
                        mag_z_reg <= mag_z_reg << 1;
                    end
                    else
                    begin
                        s_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= N_SQUARE;
                    end
                end
                N_SQUARE:
                begin
                    // one square per cycle, accumulated in the next cycle
                    if (cnt_reg != 5'd3)
                    begin
                        prod_reg <= {30'd0, sq_op} * {30'd0, sq_op};
                    end
                    if (cnt_reg != 5'd0)
                    begin
                        s_reg <= s_reg + 64'(prod_reg);
                    end
                    if (cnt_reg == 5'd3)
                    begin
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= N_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_SQRT:
                begin
                    // one result bit per cycle
                    if (s_reg >= root_try)
                    begin
                        s_reg   <= s_reg - root_try;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == 5'd31)
                    begin
                        j_reg     <= '0;
                        state_reg <= N_DLOAD;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                N_DLOAD:
                begin
                    // quotient fits 15 bits, so the top part starts below the root
                    rem_reg   <= 32'(dividend[44:QUOT_BITS]);
                    low_reg   <= dividend[QUOT_BITS-1:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= N_DSTEP;
                end
                N_DSTEP:
                begin
                    rem_reg <= qbit ? 32'(trial - 33'(root)) : 32'(trial);
                    low_reg <= {low_reg[QUOT_BITS-2:0], 1'b0};
                    q_reg   <= q_new;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(QUOT_BITS - 1))
                    begin
                        case (j_reg)
                            2'd0:    nx_reg <= q_signed;
                            2'd1:    ny_reg <= q_signed;
                            default: nz_reg <= q_signed;
                        endcase
                        if (j_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= N_DLOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign norm_x    = nx_reg;
    assign norm_y    = ny_reg;
    assign norm_z    = nz_reg;
    assign stat.busy = (state_reg != N_IDLE);
    assign stat.done = done_reg;

endmodule

// File: sv/vertex_normal_estimator.sv
// ---------------------------------------------------------------------------
// vertex_normal_estimator
// vertex table with per-vertex face normal sums and q1.14 normal readout
// ---------------------------------------------------------------------------
// usage
//   s_* carries one request: s_tuser holds the kind (write vertex, add
//   triangle, read normal), s_tdata the index, coordinates and corners.
//   m_* returns one result per request: three q1.14 normal components in
//   m_tdata and the range error flag in m_tuser. cfg_wr_en / cfg_wr_data set
//   vertex_count; the user must write it while the block is idle (not enforced).
// timing
//   requests are handled one at a time; s_tready is high only when idle.
//   a vertex write skips the normalizer; a normal read and a triangle use
//   the shared normalizer: a shift loop, 32 square root steps and three
//   15-step divisions, plus the single-port vertex and sum memory reads.
// reset
//   after reset a clearing pass writes VERTEX_DEPTH zero sums, one per
//   cycle, before the first request is taken.
// stall
//   a finished result waits in the output register; the next request may be
//   taken meanwhile but its result waits until m_tready frees the register.
// ---------------------------------------------------------------------------
module vertex_normal_estimator #(
    parameter int VERTEX_DEPTH = 1024,
    parameter int COORD_BITS   = 20,
    parameter int SUM_BITS     = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [vne_pkg::CFG_BITS-1:0]           cfg_wr_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [((4*vne_pkg::IDX_BITS+3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [vne_pkg::KIND_BITS-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // normal_x, normal_y, normal_z
    output logic [3*vne_pkg::NORM_BITS-1:0]        m_tdata,
    // status
    output logic                                   m_tuser
);
    import vne_pkg::*;

    localparam int AW   = $clog2(VERTEX_DEPTH);
    localparam int EW   = COORD_BITS + 1;
    localparam int CW   = 2 * EW + 1;
    localparam int NW0  = (CW > SUM_BITS) ? CW : SUM_BITS;
    localparam int NW   = (NW0 > 31) ? NW0 : 31;
    localparam int VW   = 3 * COORD_BITS;
    localparam int SW   = 3 * SUM_BITS;
    localparam logic signed [SUM_BITS:0] SUM_HI =
        (SUM_BITS+1)'((64'd1 << (SUM_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_BITS:0] SUM_LO = -SUM_HI - 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_VREAD,
        S_CROSS,
        S_NSTART,
        S_NWAIT,
        S_SLOAD,
        S_RREAD,
        S_RWRITE,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [CFG_BITS-1:0]         vertex_count_reg;
    logic [AW-1:0]               clr_reg;
    logic [2:0]                  cnt_reg;
    logic [1:0]                  ri_reg;
    logic [KIND_BITS-1:0]        kind_reg;
    logic [IDX_BITS-1:0]         vidx_reg;
    logic [VW-1:0]               coord_reg;
    logic [IDX_BITS-1:0]         corner_reg [3];
    logic signed [COORD_BITS-1:0] va_x_reg, va_y_reg, va_z_reg;
    logic signed [EW-1:0]        e1x_reg, e1y_reg, e1z_reg;
    logic signed [EW-1:0]        e2x_reg, e2y_reg, e2z_reg;
    logic signed [63:0]          prod_reg;
    logic signed [NW:0]          cmp_x_reg, cmp_y_reg, cmp_z_reg;
    logic signed [NORM_BITS-1:0] f_x_reg, f_y_reg, f_z_reg;
    logic signed [NORM_BITS-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic                        res_status_reg;
    logic signed [NORM_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                        out_status_reg;
    logic                        m_tvalid_reg;
    logic                        nstart_reg;

    logic [VW-1:0]               vtx_mem [VERTEX_DEPTH];
    logic [VW-1:0]               vtx_rd_reg;
    logic [SW-1:0]               sum_mem [VERTEX_DEPTH];
    logic [SW-1:0]               sum_rd_reg;

    logic                        vtx_we;
    logic [AW-1:0]               vtx_addr;
    logic                        sum_we;
    logic [AW-1:0]               sum_addr;
    logic [SW-1:0]               sum_wdata;
    logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
    logic signed [SUM_BITS-1:0]  sm_x, sm_y, sm_z;
    logic signed [31:0]          mul_a, mul_b;
    logic signed [63:0]          mul_p;
    logic signed [NW:0]          prod_t;
    logic                        ok_vidx;
    logic                        ok_tri;
    logic                        out_free;
    logic signed [NORM_BITS-1:0] nrm_x, nrm_y, nrm_z;
    norm_stat_t                  nstat;

    // index range check against the register and the table depth
    function automatic logic idx_ok(input logic [IDX_BITS-1:0] idx,
                                    input logic [CFG_BITS-1:0] count);
        idx_ok = (CFG_BITS'(idx) < count) && (32'(idx) < VERTEX_DEPTH);
    endfunction

    // saturating add of a q1.14 component into a sum
    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0]  s,
        input logic signed [NORM_BITS-1:0] f);
        logic signed [SUM_BITS:0] t;
        t = (SUM_BITS+1)'(s) + (SUM_BITS+1)'(f);
        if (t > SUM_HI)
        begin
            sat_add = SUM_HI[SUM_BITS-1:0];
        end
        else if (t < SUM_LO)
        begin
            sat_add = SUM_LO[SUM_BITS-1:0];
        end
        else
        begin
            sat_add = t[SUM_BITS-1:0];
        end
    endfunction

    // field views
    always_comb
    begin
        rd_x    = vtx_rd_reg[0 +: COORD_BITS];
        rd_y    = vtx_rd_reg[COORD_BITS +: COORD_BITS];
        rd_z    = vtx_rd_reg[2*COORD_BITS +: COORD_BITS];
        sm_x    = sum_rd_reg[0 +: SUM_BITS];
        sm_y    = sum_rd_reg[SUM_BITS +: SUM_BITS];
        sm_z    = sum_rd_reg[2*SUM_BITS +: SUM_BITS];
        ok_vidx = idx_ok(vidx_reg, vertex_count_reg);
        ok_tri  = idx_ok(corner_reg[0], vertex_count_reg)
               && idx_ok(corner_reg[1], vertex_count_reg)
               && idx_ok(corner_reg[2], vertex_count_reg);
        out_free = !m_tvalid_reg || m_tready;
    end

    // memory port control
    always_comb
    begin
        vtx_we    = (state_reg == S_DECODE) && (kind_reg == KIND_WRITE) && ok_vidx;
        vtx_addr  = AW'(vidx_reg);
        if (state_reg == S_VREAD)
        begin
            case (cnt_reg)
                3'd0:    vtx_addr = AW'(corner_reg[0]);
                3'd1:    vtx_addr = AW'(corner_reg[1]);
                default: vtx_addr = AW'(corner_reg[2]);
            endcase
        end
        sum_we    = (state_reg == S_CLEAR) || vtx_we || (state_reg == S_RWRITE);
        sum_wdata = '0;
        sum_addr  = AW'(vidx_reg);
        case (state_reg)
            S_CLEAR:
            begin
                sum_addr = clr_reg;
            end
            S_RREAD, S_RWRITE:
            begin
                sum_addr  = AW'(corner_reg[ri_reg]);
                sum_wdata = {sat_add(sm_z, f_z_reg), sat_add(sm_y, f_y_reg),
                             sat_add(sm_x, f_x_reg)};
            end
            default:
            begin
                sum_addr = AW'(vidx_reg);
            end
        endcase
    end

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[vtx_addr] <= coord_reg;
        end
        vtx_rd_reg <= vtx_mem[vtx_addr];
    end

    // normal sum memory
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[sum_addr];
    end

    // cross product operand selection, one product per cycle
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin mul_a = 32'(e1y_reg); mul_b = 32'(e2z_reg); end
            3'd1:    begin mul_a = 32'(e1z_reg); mul_b = 32'(e2y_reg); end
            3'd2:    begin mul_a = 32'(e1z_reg); mul_b = 32'(e2x_reg); end
            3'd3:    begin mul_a = 32'(e1x_reg); mul_b = 32'(e2z_reg); end
            3'd4:    begin mul_a = 32'(e1x_reg); mul_b = 32'(e2y_reg); end
            default: begin mul_a = 32'(e1y_reg); mul_b = 32'(e2x_reg); end
        endcase
        mul_p  = mul_a * mul_b;
        prod_t = (NW+1)'(prod_reg);
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            vertex_count_reg <= CFG_BITS'(1024);
            clr_reg          <= '0;
            cnt_reg          <= '0;
            ri_reg           <= '0;
            m_tvalid_reg     <= 1'b0;
            nstart_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vertex_count_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            nstart_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(VERTEX_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg      <= s_tuser;
                        vidx_reg      <= s_tdata[0 +: IDX_BITS];
                        coord_reg     <= s_tdata[IDX_BITS +: VW];
                        corner_reg[0] <= s_tdata[IDX_BITS+VW +: IDX_BITS];
                        corner_reg[1] <= s_tdata[2*IDX_BITS+VW +: IDX_BITS];
                        corner_reg[2] <= s_tdata[3*IDX_BITS+VW +: IDX_BITS];
                        state_reg     <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_z_reg      <= '0;
                    res_status_reg <= STATUS_DONE;
                    cnt_reg        <= '0;
                    unique case (kind_reg)
                        KIND_WRITE:
                        begin
                            res_status_reg <= ok_vidx ? STATUS_DONE : STATUS_RANGE;
                            state_reg      <= S_DONE;
                        end
                        KIND_TRIANGLE:
                        begin
                            res_status_reg <= ok_tri ? STATUS_DONE : STATUS_RANGE;
                            state_reg      <= ok_tri ? S_VREAD : S_DONE;
                        end
                        KIND_READ:
                        begin
                            res_status_reg <= ok_vidx ? STATUS_DONE : STATUS_RANGE;
                            state_reg      <= ok_vidx ? S_SLOAD : S_DONE;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_VREAD:
                begin
                    // corner reads return in the cycle after the address
                    cnt_reg <= cnt_reg + 3'd1;
                    case (cnt_reg)
                        3'd1:
                        begin
                            va_x_reg <= rd_x;
                            va_y_reg <= rd_y;
                            va_z_reg <= rd_z;
                        end
                        3'd2:
                        begin
                            e1x_reg <= EW'(rd_x) - EW'(va_x_reg);
                            e1y_reg <= EW'(rd_y) - EW'(va_y_reg);
                            e1z_reg <= EW'(rd_z) - EW'(va_z_reg);
                        end
                        3'd3:
                        begin
                            e2x_reg   <= EW'(rd_x) - EW'(va_x_reg);
                            e2y_reg   <= EW'(rd_y) - EW'(va_y_reg);
                            e2z_reg   <= EW'(rd_z) - EW'(va_z_reg);
                            cnt_reg   <= '0;
                            state_reg <= S_CROSS;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_CROSS:
                begin
                    // product registered, then folded into its component
                    prod_reg <= mul_p;
                    cnt_reg  <= cnt_reg + 3'd1;
                    case (cnt_reg)
                        3'd1:    cmp_x_reg <= prod_t;
                        3'd2:    cmp_x_reg <= cmp_x_reg - prod_t;
                        3'd3:    cmp_y_reg <= prod_t;
                        3'd4:    cmp_y_reg <= cmp_y_reg - prod_t;
                        3'd5:    cmp_z_reg <= prod_t;
                        3'd6:    cmp_z_reg <= cmp_z_reg - prod_t;
                        default:
                        begin
                        end
                    endcase
                    if (cnt_reg == 3'd6)
                    begin
                        state_reg <= S_NSTART;
                    end
                end
                S_SLOAD:
                begin
                    cmp_x_reg <= (NW+1)'(sm_x);
                    cmp_y_reg <= (NW+1)'(sm_y);
                    cmp_z_reg <= (NW+1)'(sm_z);
                    state_reg <= S_NSTART;
                end
                S_NSTART:
                begin
                    nstart_reg <= 1'b1;
                    state_reg  <= S_NWAIT;
                end
                S_NWAIT:
                begin
                    if (nstat.done)
                    begin
                        if (kind_reg == KIND_TRIANGLE)
                        begin
                            f_x_reg   <= nrm_x;
                            f_y_reg   <= nrm_y;
                            f_z_reg   <= nrm_z;
                            ri_reg    <= '0;
                            state_reg <= S_RREAD;
                        end
                        else
                        begin
                            res_x_reg <= nrm_x;
                            res_y_reg <= nrm_y;
                            res_z_reg <= nrm_z;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_RREAD:
                begin
                    state_reg <= S_RWRITE;
                end
                S_RWRITE:
                begin
                    // corners one after another so a repeated corner adds twice
                    if (ri_reg == 2'd2)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ri_reg    <= ri_reg + 2'd1;
                        state_reg <= S_RREAD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_x_reg      <= res_x_reg;
                        out_y_reg      <= res_y_reg;
                        out_z_reg      <= res_z_reg;
                        out_status_reg <= res_status_reg;
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // shared normalizer
    vne_normalize #(
        .MAG_BITS (NW)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (nstart_reg),
        .comp_x (cmp_x_reg),
        .comp_y (cmp_y_reg),
        .comp_z (cmp_z_reg),
        .norm_x (nrm_x),
        .norm_y (nrm_y),
        .norm_z (nrm_z),
        .stat   (nstat)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_status_reg;

endmodule

// File: sv/vne_checker.sv
// ---------------------------------------------------------------------------
// vne_checker
// port-level checks of the vertex normal estimator, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vne_checker #(
    parameter int COORD_BITS = 20
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [3*vne_pkg::NORM_BITS-1:0]        m_tdata,
    input logic                                   m_tuser
);
    import vne_pkg::*;

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one request at a time
    `ASSERT_CLK(a_one_request, clk, rst_n, s_tvalid && s_tready |=> !s_tready)

    // a range error carries a zero normal
    `ASSERT_IMPLIES(a_error_zero, clk, rst_n, m_tvalid && (m_tuser == STATUS_RANGE), m_tdata == '0)

    // components stay within the unit range
    `ASSERT_IMPLIES(a_unit_range, clk, rst_n, m_tvalid, ($signed(m_tdata[15:0]) <= 16384) && ($signed(m_tdata[15:0]) >= -16384) && ($signed(m_tdata[31:16]) <= 16384) && ($signed(m_tdata[31:16]) >= -16384) && ($signed(m_tdata[47:32]) <= 16384) && ($signed(m_tdata[47:32]) >= -16384))

endmodule

bind vertex_normal_estimator vne_checker #(
    .COORD_BITS (COORD_BITS)
) u_vne_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
